@@ hdl/gar_pkg.sv @@
`default_nettype none

package gar_pkg;

    localparam int OP_W  = 2;
    localparam int VTX_W = 6;
    localparam int NUM_W = 7;
    localparam int CNT_W = 11;
    localparam int ST_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NO_CHANGE = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE_CHK,
        S_EDGE_WB,
        S_PICK,
        S_EXPAND
    } t_state;

    // adjacency store commands
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_adj_ctl;

endpackage

`default_nettype wire

@@ hdl/gar_ram.sv @@
`default_nettype none

module gar_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

@@ hdl/gar_adj_store.sv @@
`default_nettype none

module gar_adj_store import gar_pkg::*; #(
    parameter int NV = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_adj_ctl              i_ctl,
    input  wire logic [$clog2(NV)-1:0] i_rd_addr,
    input  wire logic [$clog2(NV)-1:0] i_wr_addr,
    input  wire logic [NV-1:0]         i_wr_data,
    output logic      [NV-1:0]         o_rd_data
);

    logic [NV-1:0] r_valid;
    logic          r_rd_vld;
    logic [NV-1:0] w_ram_q;

    // a row never written since the last clear reads as empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_valid <= '0;
            end else if (i_ctl.wr) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    gar_ram #(
        .WIDTH(NV),
        .DEPTH(NV)
    ) u_rows (
        .i_clk  (i_clk),
        .i_we   (i_ctl.wr),
        .i_waddr(i_wr_addr),
        .i_wdata(i_wr_data),
        .i_re   (i_ctl.rd),
        .i_raddr(i_rd_addr),
        .o_rdata(w_ram_q)
    );

    assign o_rd_data = r_rd_vld ? w_ram_q : '0;

endmodule

`default_nettype wire

@@ hdl/graph_adjacency_reachability.sv @@
`default_nettype none

// Result path, accepting edge to o_done: clear, out-of-range and a = b items finish in S_IDLE;
// a duplicate insert or absent remove finishes at the check, and an edge write runs row read, check and write,
// partner row write-back. Query: a pick step and an expand step for each vertex expanded;
// it stops early once the target is marked.
// Throughput: a new item is taken in the cycle o_done is shown; results are never stalled.
// Sync reset empties the graph at once via per-row valid bits; num_vertices resets to 64.
module graph_adjacency_reachability import gar_pkg::*; #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [OP_W-1:0]  i_operation,
    input  wire logic [VTX_W-1:0] i_vertex_a,
    input  wire logic [VTX_W-1:0] i_vertex_b,
    output logic                  o_done,
    output logic                  o_reachable,
    output logic [CNT_W-1:0]      o_edge_count,
    output logic [ST_W-1:0]       o_status,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int VW        = $clog2(MAX_VERTICES);
    localparam int NW        = $clog2(MAX_VERTICES + 1);
    localparam int MAX_EDGES = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
    localparam int ECW       = $clog2(MAX_EDGES + 1);
    localparam logic [MAX_VERTICES-1:0] ONE = MAX_VERTICES'(1);

    t_state                  r_state, n_state;
    t_op                     r_op;
    logic [VW-1:0]           r_a, r_b;
    logic [MAX_VERTICES-1:0] r_visited, r_pending;
    logic [NUM_W-1:0]        r_num_vertices;
    logic [ECW-1:0]          r_edges;
    logic                    r_done, r_reach;
    t_status                 r_status;

    logic [NW-1:0]           w_nv;
    logic [MAX_VERTICES-1:0] w_mask, w_row, w_new, w_wr_data;
    logic [VW-1:0]           w_a, w_b, w_pick, w_rd_addr, w_wr_addr;
    logic                    w_in_range, w_insert;
    t_adj_ctl                w_ctl;
    logic                    w_fin, w_fin_reach;
    t_status                 w_fin_status;
    logic                    w_latch, w_q_init, w_pick_go, w_expand;
    logic                    w_edge_inc, w_edge_dec, w_edge_clr;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vertices <= NUM_W'(64);
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_num_vertices <= pwdata[NUM_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : 32'(r_num_vertices);

    assign w_nv = (32'(r_num_vertices) > MAX_VERTICES) ? NW'(MAX_VERTICES)
                                                      : NW'(r_num_vertices);

    always_comb begin
        for (int w = 0; w < MAX_VERTICES; w++) begin
            w_mask[w] = (w < int'(w_nv));
        end
    end

    assign w_in_range = (32'(i_vertex_a) < 32'(w_nv)) && (32'(i_vertex_b) < 32'(w_nv));
    assign w_a        = VW'(i_vertex_a);
    assign w_b        = VW'(i_vertex_b);
    assign w_insert   = (r_op == OP_INSERT);
    assign w_new      = w_row & w_mask & ~r_visited;

    // lowest pending vertex
    always_comb begin
        w_pick = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (r_pending[i]) begin
                w_pick = VW'(i);
            end
        end
    end

    gar_adj_store #(
        .NV(MAX_VERTICES)
    ) u_adj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_rd_addr(w_rd_addr),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .o_rd_data(w_row)
    );

    // control outputs
    always_comb begin
        w_ctl        = '0;
        w_rd_addr    = '0;
        w_wr_addr    = '0;
        w_wr_data    = '0;
        w_fin        = 1'b0;
        w_fin_reach  = 1'b0;
        w_fin_status = ST_DONE;
        w_latch      = 1'b0;
        w_q_init     = 1'b0;
        w_pick_go    = 1'b0;
        w_expand     = 1'b0;
        w_edge_inc   = 1'b0;
        w_edge_dec   = 1'b0;
        w_edge_clr   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    w_latch = 1'b1;
                    priority if (t_op'(i_operation) == OP_CLEAR) begin
                        w_ctl.clr  = 1'b1;
                        w_edge_clr = 1'b1;
                        w_fin      = 1'b1;
                    end else if (!w_in_range) begin
                        w_fin        = 1'b1;
                        w_fin_status = ST_RANGE;
                    end else if (w_a == w_b) begin
                        w_fin = 1'b1;
                        if (t_op'(i_operation) == OP_QUERY) begin
                            w_fin_reach = 1'b1;
                        end else begin
                            w_fin_status = ST_NO_CHANGE;
                        end
                    end else if (t_op'(i_operation) == OP_QUERY) begin
                        w_q_init = 1'b1;
                    end else begin
                        w_ctl.rd  = 1'b1;
                        w_rd_addr = w_a;
                    end
                end
            end
            S_EDGE_CHK: begin
                // insert of a present edge or remove of an absent one
                if (w_insert == w_row[r_b]) begin
                    w_fin        = 1'b1;
                    w_fin_status = ST_NO_CHANGE;
                end else begin
                    w_ctl.wr  = 1'b1;
                    w_wr_addr = r_a;
                    w_wr_data = w_insert ? (w_row | (ONE << r_b)) : (w_row & ~(ONE << r_b));
                    w_ctl.rd  = 1'b1;
                    w_rd_addr = r_b;
                end
            end
            S_EDGE_WB: begin
                w_ctl.wr  = 1'b1;
                w_wr_addr = r_b;
                w_wr_data = w_insert ? (w_row | (ONE << r_a)) : (w_row & ~(ONE << r_a));
                w_fin     = 1'b1;
                if (w_insert) begin
                    w_edge_inc = 1'b1;
                end else begin
                    w_edge_dec = 1'b1;
                end
            end
            S_PICK: begin
                if (r_visited[r_b]) begin
                    w_fin       = 1'b1;
                    w_fin_reach = 1'b1;
                end else if (r_pending == '0) begin
                    w_fin = 1'b1;
                end else begin
                    w_ctl.rd  = 1'b1;
                    w_rd_addr = w_pick;
                    w_pick_go = 1'b1;
                end
            end
            S_EXPAND: begin
                w_expand = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start && !w_fin) begin
                    n_state = w_q_init ? S_PICK : S_EDGE_CHK;
                end
            end
            S_EDGE_CHK: begin
                n_state = w_fin ? S_IDLE : S_EDGE_WB;
            end
            S_EDGE_WB: begin
                n_state = S_IDLE;
            end
            S_PICK: begin
                n_state = w_fin ? S_IDLE : S_EXPAND;
            end
            S_EXPAND: begin
                n_state = S_PICK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_edges   <= '0;
            r_done    <= 1'b0;
            r_visited <= '0;
            r_pending <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= w_fin;
            if (w_edge_clr) begin
                r_edges <= '0;
            end else if (w_edge_inc) begin
                r_edges <= r_edges + ECW'(1);
            end else if (w_edge_dec) begin
                r_edges <= r_edges - ECW'(1);
            end
            priority if (w_edge_clr) begin
                r_visited <= '0;
                r_pending <= '0;
            end else if (w_q_init) begin
                r_visited <= ONE << w_a;
                r_pending <= ONE << w_a;
            end else if (w_pick_go) begin
                r_pending[w_pick] <= 1'b0;
            end else if (w_expand) begin
                r_visited <= r_visited | w_new;
                r_pending <= r_pending | w_new;
            end
        end
    end

    // item and result beat registers
    always_ff @(posedge i_clk) begin
        if (w_latch) begin
            r_op <= t_op'(i_operation);
            r_a  <= w_a;
            r_b  <= w_b;
        end
        if (w_fin) begin
            r_reach  <= w_fin_reach;
            r_status <= w_fin_status;
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_reachable  = r_reach;
    assign o_status     = r_status;
    assign o_edge_count = CNT_W'(r_edges);

endmodule

`default_nettype wire

@@ sim/tb_graph_adjacency_reachability.sv @@
`timescale 1ns / 1ps

import gar_pkg::*;

typedef struct {
    logic              reach;
    logic [CNT_W-1:0]  count;
    t_status           status;
} t_graph_outcome;

// Shadow copy of the graph; predicts one outcome per accepted beat.
class t_reach_scoreboard;
    logic [63:0]     adj_rows [64];
    int unsigned     edge_total;
    int unsigned     vertex_reg;
    int unsigned     mismatches;
    t_graph_outcome  expected_outcomes [$];

    function new();
        foreach (adj_rows[i]) adj_rows[i] = '0;
        edge_total = 0;
        vertex_reg = 64;
        mismatches = 0;
    endfunction

    function void set_vertices(logic [NUM_W-1:0] v);
        vertex_reg = v;
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    // depth-first walk, only through vertices below nv
    function bit search_reaches(int unsigned s, int unsigned t, int unsigned nv);
        logic [63:0] seen;
        int unsigned pending_vtx [$];
        int unsigned v;
        seen = '0;
        seen[s] = 1'b1;
        pending_vtx.push_back(s);
        while (pending_vtx.size() > 0) begin
            v = pending_vtx.pop_back();
            for (int w = 0; w < nv; w++) begin
                if (adj_rows[v][w] && !seen[w]) begin
                    seen[w] = 1'b1;
                    pending_vtx.push_back(w);
                end
            end
        end
        return seen[t];
    endfunction

    function void note_item(t_op op, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b);
        t_graph_outcome e;
        int unsigned nv;
        nv = (vertex_reg > 64) ? 64 : vertex_reg;
        e.reach = 1'b0;
        e.status = ST_DONE;
        if (op == OP_CLEAR) begin
            foreach (adj_rows[i]) adj_rows[i] = '0;
            edge_total = 0;
        end else if (a >= nv || b >= nv) begin
            e.status = ST_RANGE;
        end else if (op == OP_INSERT) begin
            if (a == b || adj_rows[a][b]) begin
                e.status = ST_NO_CHANGE;
            end else begin
                adj_rows[a][b] = 1'b1;
                adj_rows[b][a] = 1'b1;
                edge_total++;
            end
        end else if (op == OP_REMOVE) begin
            if (a == b || !adj_rows[a][b]) begin
                e.status = ST_NO_CHANGE;
            end else begin
                adj_rows[a][b] = 1'b0;
                adj_rows[b][a] = 1'b0;
                edge_total--;
            end
        end else begin
            e.reach = search_reaches(a, b, nv);
        end
        e.count = CNT_W'(edge_total);
        expected_outcomes.push_back(e);
    endfunction

    function void check_result(logic r, logic [CNT_W-1:0] cnt, logic [ST_W-1:0] st);
        t_graph_outcome e;
        if (expected_outcomes.size() == 0) begin
            flag($sformatf("unexpected result reach=%0b count=%0d status=%0d", r, cnt, st));
            return;
        end
        e = expected_outcomes.pop_front();
        if (r !== e.reach || cnt !== e.count || st !== e.status)
            flag($sformatf("exp reach=%0b count=%0d status=%0d, got reach=%0b count=%0d status=%0d",
                           e.reach, e.count, e.status, r, cnt, st));
    endfunction

    function int unsigned outstanding();
        return expected_outcomes.size();
    endfunction

    function int unsigned error_total();
        return mismatches + expected_outcomes.size();
    endfunction
endclass

module tb_graph_adjacency_reachability;

    localparam logic [2:0] REG_NUM_VERTICES = 3'd0;
    localparam int         STALL_LIMIT      = 2000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [OP_W-1:0]    i_operation = '0;
    logic [VTX_W-1:0]   i_vertex_a = '0;
    logic [VTX_W-1:0]   i_vertex_b = '0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic               busy;
    logic               o_done;
    logic               o_reachable;
    logic [CNT_W-1:0]   o_edge_count;
    logic [ST_W-1:0]    o_status;
    logic [31:0]        prdata;
    logic               pready;

    t_reach_scoreboard  sb;
    logic [11:0]        recent_edges [$];
    int unsigned        stall_cycles = 0;
    int unsigned        phase_cfg [8] = '{64, 8, 1, 127, 16, 0, 65, 40};
    int unsigned        phase_items [8] = '{160, 130, 30, 130, 130, 30, 130, 110};

    graph_adjacency_reachability dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_vertex_a   (i_vertex_a),
        .i_vertex_b   (i_vertex_b),
        .o_done       (o_done),
        .o_reachable  (o_reachable),
        .o_edge_count (o_edge_count),
        .o_status     (o_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_reachable, o_edge_count, o_status);
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [VTX_W-1:0] pick_vertex(int unsigned nv);
        if (nv == 0 || $urandom_range(99, 0) < 15)
            return VTX_W'($urandom_range(63, 0));
        return VTX_W'($urandom_range(nv - 1, 0));
    endfunction

    // start stays high from one beat to the next unless the sender idles
    task automatic send_item(input t_op op, input logic [VTX_W-1:0] a,
                             input logic [VTX_W-1:0] b, input int unsigned idle_pct);
        if ($urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_vertex_a  <= a;
        i_vertex_b  <= b;
        do @(posedge i_clk); while (busy);
        sb.note_item(op, a, b);
    endtask

    // block idle first; write then read back the register
    task automatic set_vertex_count(input logic [NUM_W-1:0] v);
        start <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_NUM_VERTICES;
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_vertices(v);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(v))
            sb.flag($sformatf("num_vertices readback exp %0d got %0d", v, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_item(input int unsigned nv, input int unsigned idle_pct);
        int unsigned     r;
        int unsigned     idx;
        t_op             op;
        logic [VTX_W-1:0] a;
        logic [VTX_W-1:0] b;
        r = $urandom_range(99, 0);
        a = pick_vertex(nv);
        b = pick_vertex(nv);
        if (r < 45)
            op = OP_INSERT;
        else if (r < 60)
            op = OP_REMOVE;
        else if (r < 97)
            op = OP_QUERY;
        else
            op = OP_CLEAR;
        // removes mostly target edges put in earlier
        if (op == OP_REMOVE && recent_edges.size() > 0 && $urandom_range(9, 0) < 7) begin
            idx = $urandom_range(recent_edges.size() - 1, 0);
            {a, b} = recent_edges[idx];
            recent_edges.delete(idx);
        end
        if (op == OP_INSERT && recent_edges.size() < 200)
            recent_edges.push_back({a, b});
        if (op == OP_CLEAR)
            recent_edges.delete();
        send_item(op, a, b, idle_pct);
    endtask

    initial begin
        sb = new();
        phase_cfg[7] = $urandom_range(63, 2);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty graph, self-reach, duplicates, self-loops, absent removes
        send_item(OP_QUERY,  6'd0,  6'd0,  0);
        send_item(OP_QUERY,  6'd0,  6'd63, 0);
        send_item(OP_INSERT, 6'd0,  6'd63, 0);
        send_item(OP_INSERT, 6'd63, 6'd0,  0);
        send_item(OP_INSERT, 6'd5,  6'd5,  0);
        send_item(OP_INSERT, 6'd63, 6'd62, 0);
        send_item(OP_QUERY,  6'd0,  6'd62, 0);
        send_item(OP_QUERY,  6'd62, 6'd0,  0);
        send_item(OP_REMOVE, 6'd5,  6'd5,  0);
        send_item(OP_REMOVE, 6'd1,  6'd2,  0);
        send_item(OP_REMOVE, 6'd0,  6'd63, 0);
        send_item(OP_QUERY,  6'd0,  6'd62, 0);
        send_item(OP_INSERT, 6'd31, 6'd32, 0);
        send_item(OP_INSERT, 6'd42, 6'd21, 0);
        send_item(OP_CLEAR,  6'd63, 6'd63, 0);
        send_item(OP_QUERY,  6'd42, 6'd21, 0);
        // out of range vertices
        set_vertex_count(7'd10);
        send_item(OP_INSERT, 6'd10, 6'd3,  0);
        send_item(OP_QUERY,  6'd3,  6'd63, 0);
        send_item(OP_INSERT, 6'd9,  6'd0,  0);
        send_item(OP_REMOVE, 6'd0,  6'd10, 0);
        // zero vertices: everything out of range, clear still works
        set_vertex_count(7'd0);
        send_item(OP_INSERT, 6'd0,  6'd1,  0);
        send_item(OP_QUERY,  6'd0,  6'd0,  0);
        send_item(OP_CLEAR,  6'd0,  6'd0,  0);
        // shrink with edges above the limit, then saturate back to full
        set_vertex_count(7'd64);
        send_item(OP_INSERT, 6'd50, 6'd3,  0);
        send_item(OP_INSERT, 6'd3,  6'd4,  0);
        set_vertex_count(7'd10);
        send_item(OP_QUERY,  6'd3,  6'd4,  0);
        send_item(OP_REMOVE, 6'd50, 6'd3,  0);
        set_vertex_count(7'd127);
        send_item(OP_REMOVE, 6'd50, 6'd3,  0);

        for (int p = 0; p < 8; p++) begin
            set_vertex_count(NUM_W'(phase_cfg[p]));
            for (int i = 0; i < phase_items[p]; i++)
                random_item((phase_cfg[p] > 64) ? 64 : phase_cfg[p],
                            (p < 3) ? 12 : ((p < 6) ? 62 : 0));
        end

        start <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (140) @(posedge i_clk);
        if (sb.error_total() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/gar_pkg.sv
hdl/gar_ram.sv
hdl/gar_adj_store.sv
hdl/graph_adjacency_reachability.sv
sim/tb_graph_adjacency_reachability.sv
